FILE: hdl/pbsd_pkg.sv
// ----------------------------------------------------------------------------
// pbsd_pkg: shared types and constants of the BAR sizing decoder
// Item and record layouts, status codes, flag masks and the size helper.
// ----------------------------------------------------------------------------
package pbsd_pkg;

    localparam int SLOT_W  = 3;
    localparam int WORD_W  = 32;
    localparam int ADDR_W  = 64;
    localparam int CFG_W   = 3;
    // one bit more than a slot index, so a count up to 2**SLOT_W fits
    localparam int LIMIT_W = SLOT_W + 1;

    localparam logic [CFG_W-1:0]  SLOTS_RESET   = 3'd6;
    localparam logic [WORD_W-1:0] IO_FLAG_MASK  = 32'h0000_0003;
    localparam logic [WORD_W-1:0] MEM_FLAG_MASK = 32'h0000_000F;
    localparam logic [1:0]        MEM_TYPE_WIDE = 2'b10;
    localparam int                IO_BIT        = 0;
    localparam int                PREFETCH_BIT  = 3;

    typedef enum logic [1:0] {
        STATUS_PRESENT   = 2'd0,
        STATUS_ABSENT    = 2'd1,
        STATUS_MALFORMED = 2'd2
    } status_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic [WORD_W-1:0] original_value;
        logic [WORD_W-1:0] sizing_readback;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] record_slot;
        status_t           status;
        logic              is_memory;
        logic              is_wide;
        logic              prefetch_ok;
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_size;
    } record_t;

    // handoff from the decoder to the result register
    typedef struct packed {
        logic    load;
        record_t rec;
    } result_ctl_t;

    // low half of a 64-bit BAR waiting for its high half
    typedef struct packed {
        logic              pending;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] low_base;
        logic [WORD_W-1:0] low_sizing;
        logic              prefetch;
    } hold_t;

    // 32-bit size: two's complement of the masked read-back, zero if unimplemented
    function automatic logic [ADDR_W-1:0] size32(input logic [WORD_W-1:0] readback,
                                                 input logic [WORD_W-1:0] flag_mask);
        logic [WORD_W-1:0] bits;
        bits = readback & ~flag_mask;
        return {{(ADDR_W-WORD_W){1'b0}}, (~bits + 1'b1)};
    endfunction

endpackage

FILE: hdl/pci_bar_size_decoder.sv
// ----------------------------------------------------------------------------
// pci_bar_size_decoder: PCI BAR sizing decoder
// Turns BAR value / all-ones read-back pairs into decoded region records.
// ----------------------------------------------------------------------------
// One slot request is taken per clock. A request sits in the input register
// and is decoded in a single pass into the result register, from which its
// record is offered on the result port. The decode pass (masking plus one
// 64-bit negate) sets the sustained rate of one request per cycle; only
// downstream stalls slow it.
// A 64-bit memory BAR gives its record with the request for the high slot;
// requests whose slot is not below the clamped slot count give no record.
// cfg_ready is always high; write the slot count only while the block is idle.
// ----------------------------------------------------------------------------
module pci_bar_size_decoder #(
    parameter int MAX_SLOTS = 6
) (
    input  logic         aclk,
    input  logic         aresetn,
    // slot count register
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_data,     // slots_in_use
    // slot requests
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,      // slot_index, original_value, sizing_readback
    // decoded records
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,      // record_slot, region_base, region_size
    output logic [4:0]   m_tuser       // status, is_memory, is_wide, prefetch_ok
);
    import pbsd_pkg::*;

    logic [CFG_W-1:0] slots_reg;
    item_t            s_item;
    item_t            item;
    logic             item_valid;
    logic             take;
    logic             out_free;
    result_ctl_t      result;
    record_t          m_rec;

    // slot count register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= SLOTS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            slots_reg <= cfg_data;
        end
    end

    // unpack the request
    assign s_item.slot_index      = s_tdata[2:0];
    assign s_item.original_value  = s_tdata[34:3];
    assign s_item.sizing_readback = s_tdata[66:35];

    // advance the held request when the result register has room
    assign take = item_valid && out_free;

    pbsd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    pbsd_decode #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .take         (take),
        .item         (item),
        .slots_in_use (slots_reg),
        .result       (result)
    );

    pbsd_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_rec    (m_rec)
    );

    // pack the record
    assign m_tdata = {5'b0, m_rec.region_size, m_rec.region_base, m_rec.record_slot};
    assign m_tuser = {m_rec.prefetch_ok, m_rec.is_wide, m_rec.is_memory, m_rec.status};

    // absent and malformed records carry no region
    a_empty_record: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_rec.status != STATUS_PRESENT)) |->
        (!m_rec.is_memory && !m_rec.is_wide && !m_rec.prefetch_ok &&
         (m_rec.region_base == '0) && (m_rec.region_size == '0)))
        else $error("absent or malformed record carries region data");

    // an I/O region is never wide or prefetchable
    a_io_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_rec.is_memory) |-> (!m_rec.is_wide && !m_rec.prefetch_ok))
        else $error("I/O record with memory flags");

    // a wide pair always starts below the last slot
    a_wide_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_rec.is_wide) |->
        (({1'b0, m_rec.record_slot} + 1'b1) < LIMIT_W'(MAX_SLOTS)))
        else $error("wide record starts in the last slot");

endmodule

FILE: hdl/pbsd_in_stage.sv
// ----------------------------------------------------------------------------
// pbsd_in_stage: input register
// Captures one slot request and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
module pbsd_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  pbsd_pkg::item_t s_item,
    input  logic          take,
    output logic          item_valid,
    output pbsd_pkg::item_t item
);
    import pbsd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    // accept when empty or when the held request leaves this cycle
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            if (s_tvalid) begin
                item_next = s_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/pbsd_decode.sv
// ----------------------------------------------------------------------------
// pbsd_decode: BAR decode and low-half hold
// Decodes one slot per cycle while not stalled; keeps a 64-bit BAR's low half.
// ----------------------------------------------------------------------------
module pbsd_decode #(
    parameter int MAX_SLOTS = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         take,
    input  pbsd_pkg::item_t              item,
    input  logic [pbsd_pkg::CFG_W-1:0]   slots_in_use,
    output pbsd_pkg::result_ctl_t        result
);
    import pbsd_pkg::*;

    localparam logic [LIMIT_W-1:0] MAX_LIMIT = LIMIT_W'(MAX_SLOTS);

    hold_t             hold_reg;
    hold_t             hold_next;
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] slot_ext;
    logic              in_range;
    logic              pair_done;
    logic              is_io;
    logic              wide;
    logic              pf;
    logic [ADDR_W-1:0] joined;
    record_t           rec;
    logic              emit;

    // clamp the slot count to 1..MAX_SLOTS
    always_comb begin
        priority if (slots_in_use == '0) begin
            limit = LIMIT_W'(1);
        end else if ({1'b0, slots_in_use} > MAX_LIMIT) begin
            limit = MAX_LIMIT;
        end else begin
            limit = {1'b0, slots_in_use};
        end
    end

    assign slot_ext  = {1'b0, item.slot_index};
    assign in_range  = slot_ext < limit;
    // slot 0 drops any held half, otherwise a held half takes this item as its top
    assign pair_done = hold_reg.pending && (item.slot_index != '0);
    assign is_io     = item.original_value[IO_BIT];
    assign wide      = (item.original_value[2:1] == MEM_TYPE_WIDE);
    assign pf        = item.original_value[PREFETCH_BIT];
    assign joined    = {item.sizing_readback, hold_reg.low_sizing & ~MEM_FLAG_MASK};

    // build the record and the next hold contents
    always_comb begin
        rec       = '0;
        emit      = 1'b0;
        hold_next = hold_reg;
        rec.record_slot = item.slot_index;
        rec.status      = STATUS_PRESENT;
        if (in_range) begin
            hold_next.pending = 1'b0;
            emit              = 1'b1;
            priority if (pair_done) begin
                rec.record_slot = hold_reg.slot;
                rec.is_memory   = 1'b1;
                rec.is_wide     = 1'b1;
                rec.prefetch_ok = hold_reg.prefetch;
                rec.region_base = {item.original_value, hold_reg.low_base};
                if (item.sizing_readback != '0) begin
                    rec.region_size = ~joined + 1'b1;
                end else begin
                    rec.region_size = size32(hold_reg.low_sizing, MEM_FLAG_MASK);
                end
            end else if (item.original_value == '0) begin
                rec.status = STATUS_ABSENT;
            end else if (is_io) begin
                rec.region_base = {{(ADDR_W-WORD_W){1'b0}},
                                   item.original_value & ~IO_FLAG_MASK};
                rec.region_size = size32(item.sizing_readback, IO_FLAG_MASK);
            end else if (!wide) begin
                rec.is_memory   = 1'b1;
                rec.prefetch_ok = pf;
                rec.region_base = {{(ADDR_W-WORD_W){1'b0}},
                                   item.original_value & ~MEM_FLAG_MASK};
                rec.region_size = size32(item.sizing_readback, MEM_FLAG_MASK);
            end else if ((slot_ext + 1'b1) >= limit) begin
                rec.status = STATUS_MALFORMED;
            end else begin
                // hold the low half, no record yet
                emit                   = 1'b0;
                hold_next.pending      = 1'b1;
                hold_next.slot         = item.slot_index;
                hold_next.low_base     = item.original_value & ~MEM_FLAG_MASK;
                hold_next.low_sizing   = item.sizing_readback;
                hold_next.prefetch     = pf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
        end else if (take) begin
            hold_reg <= hold_next;
        end
    end

    assign result.load = take && emit;
    assign result.rec  = rec;

endmodule

FILE: hdl/pbsd_out_stage.sv
// ----------------------------------------------------------------------------
// pbsd_out_stage: result register
// Holds one decoded record until the downstream side takes it.
// ----------------------------------------------------------------------------
module pbsd_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pbsd_pkg::result_ctl_t result,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output pbsd_pkg::record_t     m_rec
);
    import pbsd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    record_t rec_reg;
    record_t rec_next;

    // the register can take a new record when empty or being drained
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (free) begin
            valid_next = result.load;
        end
        if (result.load) begin
            rec_next = result.rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign m_tvalid = valid_reg;
    assign m_rec    = rec_reg;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pci_bar_size_decoder
// Streams BAR slot requests into the decoder under random sender bursts and
// receiver stalls, predicts each decoded record in a scoreboard class, and
// compares every record that leaves the block against the oldest prediction.
// The slot count register is rewritten between phases, including the values
// that clamp at either end.
// ----------------------------------------------------------------------------
module testbench;
    import pbsd_pkg::*;

    localparam int MAX_SLOTS      = 6;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int REPORT_LIMIT   = 10;

    // kinds of BAR the stimulus builds
    localparam int KIND_ABSENT = 0;
    localparam int KIND_IO     = 1;
    localparam int KIND_MEM32  = 2;
    localparam int KIND_MEM64  = 3;

    // receiver pacing modes
    localparam logic [1:0] PACE_FULL  = 2'd0;
    localparam logic [1:0] PACE_COIN  = 2'd1;
    localparam logic [1:0] PACE_TRAIN = 2'd2;
    localparam logic [1:0] PACE_CHOKE = 2'd3;

    // Predict decoded records and hold them until the block gives them.
    class bar_decode_scoreboard;
        logic [CFG_W-1:0]  slot_count;
        logic              half_pending;
        logic [SLOT_W-1:0] held_slot;
        logic [WORD_W-1:0] held_low_base;
        logic [WORD_W-1:0] held_low_sizing;
        logic              held_prefetch;
        record_t           expected_records[$];
        int                mismatch_count;

        function new();
            slot_count        = SLOTS_RESET;
            half_pending      = 1'b0;
            held_slot         = '0;
            held_low_base     = '0;
            held_low_sizing   = '0;
            held_prefetch     = 1'b0;
            mismatch_count    = 0;
        endfunction

        function void set_slot_count(logic [CFG_W-1:0] value);
            slot_count = value;
        endfunction

        // clamp the register to the slots the block really has
        function int active_slots();
            if (slot_count == 0) return 1;
            if (slot_count > MAX_SLOTS) return MAX_SLOTS;
            return slot_count;
        endfunction

        function logic [ADDR_W-1:0] masked_size(logic [WORD_W-1:0] readback,
                                                logic [WORD_W-1:0] flags);
            logic [WORD_W-1:0] bits;
            bits = readback & ~flags;
            if (bits == '0) return '0;
            return {32'd0, ~bits + 32'd1};
        endfunction

        // Decode one accepted request; return 0 when the slot is out of range.
        function bit note_request(item_t req);
            record_t           rec;
            logic [ADDR_W-1:0] joined;
            logic [WORD_W-1:0] orig;
            orig = req.original_value;
            if (req.slot_index >= active_slots()) return 1'b0;
            // slot 0 starts a new header, so drop any held low half
            if (req.slot_index == '0) half_pending = 1'b0;
            rec = '0;
            rec.record_slot = req.slot_index;
            rec.status = STATUS_PRESENT;
            if (half_pending) begin
                half_pending = 1'b0;
                rec.record_slot = held_slot;
                rec.is_memory = 1'b1;
                rec.is_wide = 1'b1;
                rec.prefetch_ok = held_prefetch;
                rec.region_base = {orig, held_low_base};
                if (req.sizing_readback != '0) begin
                    joined = {req.sizing_readback, held_low_sizing & ~MEM_FLAG_MASK};
                    rec.region_size = ~joined + 64'd1;
                end else begin
                    rec.region_size = masked_size(held_low_sizing, MEM_FLAG_MASK);
                end
            end else if (orig == '0) begin
                rec.status = STATUS_ABSENT;
            end else if (orig[IO_BIT]) begin
                rec.region_base = {32'd0, orig & ~IO_FLAG_MASK};
                rec.region_size = masked_size(req.sizing_readback, IO_FLAG_MASK);
            end else if (orig[2:1] != MEM_TYPE_WIDE) begin
                rec.is_memory = 1'b1;
                rec.prefetch_ok = orig[PREFETCH_BIT];
                rec.region_base = {32'd0, orig & ~MEM_FLAG_MASK};
                rec.region_size = masked_size(req.sizing_readback, MEM_FLAG_MASK);
            end else if (req.slot_index + 1 >= active_slots()) begin
                rec.status = STATUS_MALFORMED;
            end else begin
                // hold the low half until the high half arrives
                half_pending = 1'b1;
                held_slot = req.slot_index;
                held_low_base = orig & ~MEM_FLAG_MASK;
                held_low_sizing = req.sizing_readback;
                held_prefetch = orig[PREFETCH_BIT];
                return 1'b1;
            end
            expected_records.push_back(rec);
            return 1'b1;
        endfunction

        function void check_record(record_t got);
            record_t want;
            if (expected_records.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected record: slot=%0d status=%0d base=%h size=%h",
                             got.record_slot, got.status, got.region_base,
                             got.region_size);
                return;
            end
            want = expected_records.pop_front();
            if (got.record_slot !== want.record_slot || got.status !== want.status ||
                got.is_memory !== want.is_memory || got.is_wide !== want.is_wide ||
                got.prefetch_ok !== want.prefetch_ok ||
                got.region_base !== want.region_base ||
                got.region_size !== want.region_size) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("record mismatch: exp slot=%0d st=%0d mem=%0b wide=%0b pf=%0b",
                             want.record_slot, want.status, want.is_memory,
                             want.is_wide, want.prefetch_ok);
                    $display("    exp base=%h size=%h", want.region_base,
                             want.region_size);
                    $display("    got slot=%0d st=%0d mem=%0b wide=%0b pf=%0b",
                             got.record_slot, got.status, got.is_memory,
                             got.is_wide, got.prefetch_ok);
                    $display("    got base=%h size=%h", got.region_base,
                             got.region_size);
                end
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [4:0]   m_tuser;

    bar_decode_scoreboard board;
    int         burst_left;
    int         live_items;
    int         idle_cycles;
    logic [1:0] pace_mode;
    int         pace_left;
    logic [7:0] pace_tick;
    record_t    seen_record;

    pci_bar_size_decoder #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Pace the receiver: switch between full rate, coin flips, trains and chokes.
    always @(posedge aclk) begin
        if (pace_left == 0) begin
            pace_mode <= 2'($urandom_range(0, 3));
            pace_left <= $urandom_range(16, 96);
        end else begin
            pace_left <= pace_left - 1;
        end
        pace_tick <= pace_tick + 8'd1;
        case (pace_mode)
            PACE_FULL:  m_tready <= 1'b1;
            PACE_COIN:  m_tready <= 1'($urandom_range(0, 1));
            PACE_TRAIN: m_tready <= (pace_tick[2:0] < 3'd3);
            default:    m_tready <= (pace_tick[3:0] == 4'd0);
        endcase
    end

    // Check every record the block hands over.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_record.record_slot = m_tdata[2:0];
            seen_record.region_base = m_tdata[66:3];
            seen_record.region_size = m_tdata[130:67];
            seen_record.status      = status_t'(m_tuser[1:0]);
            seen_record.is_memory   = m_tuser[2];
            seen_record.is_wide     = m_tuser[3];
            seen_record.prefetch_ok = m_tuser[4];
            board.check_record(seen_record);
        end
    end

    // Stop a hung run: count cycles in which no handshake completes.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic item_t make_item(int slot, logic [31:0] orig, logic [31:0] rb);
        item_t it;
        it.slot_index = 3'(slot);
        it.original_value = orig;
        it.sizing_readback = rb;
        return it;
    endfunction

    function automatic int pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return KIND_ABSENT;
        if (r < 40) return KIND_IO;
        if (r < 70) return KIND_MEM32;
        return KIND_MEM64;
    endfunction

    function automatic logic [31:0] bar_word(int kind);
        logic [31:0] v;
        v = $urandom;
        case (kind)
            KIND_ABSENT: v = '0;
            KIND_IO:     v[IO_BIT] = 1'b1;
            KIND_MEM32: begin
                v[IO_BIT] = 1'b0;
                case ($urandom_range(0, 2))
                    0:       v[2:1] = 2'b00;
                    1:       v[2:1] = 2'b01;
                    default: v[2:1] = 2'b11;
                endcase
            end
            default: begin
                v[IO_BIT] = 1'b0;
                v[2:1] = MEM_TYPE_WIDE;
            end
        endcase
        return v;
    endfunction

    // Read-back of a low slot: mostly an address mask with the flag bits kept.
    function automatic logic [31:0] sizing_word(logic [31:0] orig);
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return $urandom;
            3:       return '1;
            default: return (32'hFFFF_FFFF << $urandom_range(0, 31)) |
                            (orig & MEM_FLAG_MASK);
        endcase
    endfunction

    // Read-back of a high slot: unimplemented, full, random, or a mask.
    function automatic logic [31:0] upper_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4, 5, 6:    return '1;
            7:          return $urandom;
            default:    return 32'hFFFF_FFFF << $urandom_range(0, 31);
        endcase
    endfunction

    // Offer one request and hold it until taken; end a burst with a gap.
    task automatic send_request(input item_t it);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, it.sizing_readback, it.original_value, it.slot_index};
        do @(posedge aclk); while (!s_tready);
        if (board.note_request(it)) live_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
    endtask

    // Drain the block, let it settle, then write the slot count.
    task automatic write_slot_count(input logic [2:0] value);
        idle_sender();
        while (board.expected_records.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_slot_count(value);
    endtask

    // Walk one header: slots in ascending order, 64-bit BARs taking two.
    task automatic send_header(input int lim);
        int          s;
        int          kind;
        logic [31:0] orig;
        s = 0;
        while (s < lim) begin
            kind = pick_kind();
            orig = bar_word(kind);
            send_request(make_item(s, orig, sizing_word(orig)));
            if (kind == KIND_MEM64 && s + 1 < lim) begin
                orig = $urandom;
                send_request(make_item(s + 1, orig, upper_word()));
                s += 2;
            end else begin
                s++;
            end
        end
    endtask

    // Send noise: raw requests, stray slots and broken 64-bit pairs.
    task automatic send_noise();
        logic [31:0] orig;
        case ($urandom_range(0, 3))
            0, 1: send_request(make_item($urandom_range(0, 7), $urandom, $urandom));
            2: begin
                orig = bar_word(KIND_MEM64);
                send_request(make_item($urandom_range(0, 7), orig, sizing_word(orig)));
                send_request(make_item($urandom_range(0, 7), $urandom, upper_word()));
            end
            default: begin
                orig = bar_word(pick_kind());
                send_request(make_item($urandom_range(0, 7), orig, sizing_word(orig)));
            end
        endcase
    endtask

    task automatic run_directed();
        // plain slots: absent, I/O, 32-bit memory, and I/O with a zero read-back
        send_request(make_item(0, 32'h0000_0000, $urandom));
        send_request(make_item(1, 32'hFFFF_FFFF, 32'hFFFF_FFFD));
        send_request(make_item(2, 32'hFFFF_FFF0, 32'hFFFF_FFFF));
        send_request(make_item(3, 32'h0000_0003, 32'h0000_0000));
        // 64-bit pair at the top with a full high read-back
        send_request(make_item(4, 32'h8000_000C, 32'h8000_000C));
        send_request(make_item(5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_item(0, 32'h0000_0002, 32'hFFFF_FFF2));
        send_request(make_item(1, 32'h0000_0006, 32'h0000_0006));
        // 64-bit pair whose high half is unimplemented
        send_request(make_item(2, 32'h1234_5674, 32'hFFF0_0004));
        send_request(make_item(3, 32'h0000_0000, 32'h0000_0000));
        // slot 0 drops a held low half
        send_request(make_item(0, 32'hFFFF_FFFC, 32'hFFFF_FFFC));
        send_request(make_item(0, 32'h0000_0000, 32'h0000_0000));
        // 64-bit BAR in the last slot, then slots past the end
        send_request(make_item(5, 32'h0000_0004, 32'hFFFF_FFF4));
        send_request(make_item(6, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_item(7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // held half survives an ignored slot; high half from the same slot index
        send_request(make_item(1, 32'hA000_0004, 32'h0000_0000));
        send_request(make_item(7, 32'h0000_0001, 32'hFFFF_FFFF));
        send_request(make_item(1, 32'h0000_0001, 32'h0000_0000));
        send_request(make_item(4, 32'h7FFF_FFF5, 32'h0000_0001));
        // small non-zero high read-back
        send_request(make_item(2, 32'h0000_0004, 32'hFFFF_FFF0));
        send_request(make_item(4, 32'hFFFF_FFFF, 32'h0000_0001));
        // slot count 0 acts as one slot
        write_slot_count(3'd0);
        send_request(make_item(0, 32'h0000_0004, 32'hFFFF_FF04));
        send_request(make_item(1, 32'h0000_0001, 32'hFFFF_FFFF));
        send_request(make_item(0, 32'h0000_0001, 32'hFFFF_FF01));
        // slot count 7 acts as the maximum
        write_slot_count(3'd7);
        send_request(make_item(5, 32'h0000_000C, 32'hFFFF_FFFC));
        send_request(make_item(6, 32'h0000_0001, 32'hFFFF_FFFF));
    endtask

    initial begin
        logic [2:0] phase_slots [8];
        int         goal;
        board       = new();
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        pace_mode   = PACE_FULL;
        pace_left   = 32;
        pace_tick   = '0;
        burst_left  = 4;
        live_items  = 0;
        idle_cycles = 0;
        phase_slots = '{3'd1, 3'd6, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        // Run random phases, one slot count each.
        foreach (phase_slots[p]) begin
            write_slot_count(phase_slots[p]);
            goal = live_items + ITEMS_PER_PHASE;
            while (live_items < goal) begin
                if ($urandom_range(0, 9) < 8)
                    send_header(board.active_slots());
                else
                    send_noise();
            end
        end

        // Drain outstanding records, then let the pipeline settle.
        idle_sender();
        while (board.expected_records.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (board.mismatch_count == 0 && board.expected_records.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/pbsd_pkg.sv
hdl/pbsd_in_stage.sv
hdl/pbsd_decode.sv
hdl/pbsd_out_stage.sv
hdl/pci_bar_size_decoder.sv
tb/testbench.sv
